// ===== src/srl_pkg.sv =====
// ----------------------------------------------------------------------------
// Shard range lookup package
// Shared field widths, table entry and result types, command codes and the
// search state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package srl_pkg;

  // Fixed field widths of the request and result items.
  localparam int BoundW = 31;
  localparam int ShardW = 8;
  localparam int HashW  = 32;
  localparam int IndexW = 8;
  localparam int CountW = 9;

  // Request kinds carried on the input tuser bit.
  typedef enum logic {
    CmdWrite  = 1'b0,
    CmdLookup = 1'b1
  } srl_cmd_e;

  // One table entry as stored in the range memory.
  typedef struct packed {
    logic [ShardW-1:0] shard;
    logic [BoundW-1:0] high;
    logic [BoundW-1:0] low;
  } srl_entry_t;

  // One lookup result.
  typedef struct packed {
    logic              found;
    logic [ShardW-1:0] shard;
    logic [IndexW-1:0] index;
  } srl_result_t;

  localparam srl_result_t MissResult = '{found: 1'b0, shard: '0, index: '0};

  // Search sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_DONE  = 3'b100
  } srl_state_e;

endpackage

`default_nettype wire

// ===== src/srl_search.sv =====
// ----------------------------------------------------------------------------
// Shard range lookup search engine
// Holds the range table in a synchronous memory and runs the binary search,
// one table probe per cycle, until a range holds the hash or the window empties.
// ----------------------------------------------------------------------------
`default_nettype none

module srl_search #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  in_cmd_i,
  input  wire logic [srl_pkg::IndexW-1:0]            in_entry_index_i,
  input  wire logic [srl_pkg::BoundW-1:0]            in_range_low_i,
  input  wire logic [srl_pkg::BoundW-1:0]            in_range_high_i,
  input  wire logic [srl_pkg::ShardW-1:0]            in_range_shard_i,
  input  wire logic [srl_pkg::HashW-1:0]             in_hash_value_i,
  input  wire logic [$clog2(TABLE_ENTRIES + 1)-1:0]  count_i,
  output logic                                       res_valid_o,
  input  wire logic                                  res_ready_i,
  output srl_pkg::srl_result_t                       res_o
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int SumW = CntW + 1;

  // Range table: one write port for write requests, one read port for probes.
  srl_pkg::srl_entry_t mem_q [TABLE_ENTRIES];
  srl_pkg::srl_entry_t rd_data_q;
  srl_pkg::srl_entry_t wr_data;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;

  // Search state.
  srl_pkg::srl_state_e          state_q, state_d;
  logic [CntW-1:0]              lo_q, lo_d;
  logic [CntW-1:0]              end_q, end_d;
  logic [IdxW-1:0]              mid_q, mid_d;
  logic [srl_pkg::BoundW-1:0]   hash_q, hash_d;
  srl_pkg::srl_result_t         res_q, res_d;

  // Probe evaluation helpers.
  logic            below_low;
  logic            above_high;
  logic [CntW-1:0] lo_nxt;
  logic [CntW-1:0] end_nxt;
  logic [SumW-1:0] sum_nxt;
  logic [IdxW-1:0] mid_nxt;
  logic [SumW-1:0] sum_first;
  logic [IdxW-1:0] mid_first;
  logic            wr_in_table;

  // Write data straight from the request.
  assign wr_data.shard = in_range_shard_i;
  assign wr_data.high  = in_range_high_i;
  assign wr_data.low   = in_range_low_i;
  assign wr_addr       = IdxW'(in_entry_index_i);
  assign wr_in_table   = (32'(in_entry_index_i) < 32'(TABLE_ENTRIES));

  // Compare the hash against the entry read in the previous cycle and narrow
  // the window [lo, end) accordingly.
  assign below_low  = (hash_q < rd_data_q.low);
  assign above_high = (hash_q > rd_data_q.high);
  assign lo_nxt     = below_low ? lo_q : (CntW'(mid_q) + CntW'(1));
  assign end_nxt    = below_low ? CntW'(mid_q) : end_q;
  assign sum_nxt    = SumW'(lo_nxt) + SumW'(end_nxt) - SumW'(1);
  assign mid_nxt    = IdxW'(sum_nxt >> 1);

  // First probe sits in the middle of [0, count).
  assign sum_first = SumW'(count_i) - SumW'(1);
  assign mid_first = IdxW'(sum_first >> 1);

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    lo_d       = lo_q;
    end_d      = end_q;
    mid_d      = mid_q;
    hash_d     = hash_q;
    res_d      = res_q;
    rd_en      = 1'b0;
    rd_addr    = mid_nxt;
    wr_en      = 1'b0;
    in_ready_o = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      srl_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        rd_addr    = mid_first;
        if (in_valid_i) begin
          if (in_cmd_i == srl_pkg::CmdWrite) begin
            wr_en = wr_in_table;
          end else if (in_hash_value_i[srl_pkg::HashW-1] || (count_i == '0)) begin
            // A hash with the top bit set is above every upper bound, and an
            // empty table holds nothing: both miss without a probe.
            res_d   = srl_pkg::MissResult;
            state_d = srl_pkg::S_DONE;
          end else begin
            hash_d  = in_hash_value_i[srl_pkg::BoundW-1:0];
            lo_d    = '0;
            end_d   = count_i;
            mid_d   = mid_first;
            rd_en   = 1'b1;
            state_d = srl_pkg::S_PROBE;
          end
        end
      end
      srl_pkg::S_PROBE: begin
        if (!below_low && !above_high) begin
          res_d.found = 1'b1;
          res_d.shard = rd_data_q.shard;
          res_d.index = srl_pkg::IndexW'(mid_q);
          state_d     = srl_pkg::S_DONE;
        end else if (lo_nxt < end_nxt) begin
          lo_d  = lo_nxt;
          end_d = end_nxt;
          mid_d = mid_nxt;
          rd_en = 1'b1;
        end else begin
          res_d   = srl_pkg::MissResult;
          state_d = srl_pkg::S_DONE;
        end
      end
      srl_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = srl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = srl_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Search payload registers.
  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    end_q  <= end_d;
    mid_q  <= mid_d;
    hash_q <= hash_d;
    res_q  <= res_d;
  end

  // Table write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // Table read port with registered data.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/shard_range_lookup_top.sv =====
// A lookup makes k = 1 .. log2(TABLE_ENTRIES) + 1 table probes (at most 9 for 256 entries);
// a hash with the top bit set or an empty table gives its miss without a probe. A write
// request gives no result. One lookup searches at a time, one probe per cycle on the single
// table read port; its result may wait in the output register while the next request is
// taken. Reset clears the sequencer, the output valid and num_ranges to 0; the table is
// undefined until written.
// ----------------------------------------------------------------------------
// Shard range lookup
// Range table with binary search: write requests store a range entry, lookup
// requests return the shard and index of the range that holds a hash.
// ----------------------------------------------------------------------------
`default_nettype none

module shard_range_lookup_top #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Configuration: num_ranges.
  input  wire logic         cfg_we_i,
  input  wire logic [8:0]   cfg_wdata_i,
  // Request stream.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [7:0] entry_index, [38:8] range_low, [69:39] range_high,
  // [77:70] range_shard, [109:78] hash_value, [111:110] zero
  input  wire logic [111:0] s_axis_tdata,
  // [0] cmd
  input  wire logic         s_axis_tuser,
  // Result stream.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [7:0] shard_number, [15:8] hit_index
  output logic [15:0]       m_axis_tdata,
  // [0] found
  output logic              m_axis_tuser
);

  localparam int CntW = $clog2(TABLE_ENTRIES + 1);

  logic [srl_pkg::CountW-1:0] num_ranges_q;
  logic [CntW-1:0]            count;
  logic                       res_valid;
  logic                       res_ready;
  srl_pkg::srl_result_t       res;
  logic                       out_valid_q, out_valid_d;
  srl_pkg::srl_result_t       out_q;

  // Range count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ranges_q <= '0;
    end else if (cfg_we_i) begin
      num_ranges_q <= cfg_wdata_i;
    end
  end

  // A count beyond the table searches the whole table.
  assign count = (32'(num_ranges_q) > 32'(TABLE_ENTRIES)) ? CntW'(TABLE_ENTRIES)
                                                          : CntW'(num_ranges_q);

  srl_search #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_search (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_cmd_i         (s_axis_tuser),
    .in_entry_index_i (s_axis_tdata[7:0]),
    .in_range_low_i   (s_axis_tdata[38:8]),
    .in_range_high_i  (s_axis_tdata[69:39]),
    .in_range_shard_i (s_axis_tdata[77:70]),
    .in_hash_value_i  (s_axis_tdata[109:78]),
    .count_i          (count),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_o            (res)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready   = !out_valid_q || m_axis_tready;
  assign out_valid_d = (res_valid && res_ready) ? 1'b1
                     : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.index, out_q.shard};
  assign m_axis_tuser  = out_q.found;

endmodule

`default_nettype wire

// ===== src/srl_checker.sv =====
// ----------------------------------------------------------------------------
// Shard range lookup port checker
// Watches the top-level streams for result stalls, miss encoding and the
// one-lookup-at-a-time request flow.
// ----------------------------------------------------------------------------
`default_nettype none

module srl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A miss carries a zero shard and a zero index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'h0000)
    else $error("miss result with nonzero payload");

  // A lookup occupies the engine, so no request is taken in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("request taken right after a lookup");

  // A write leaves the engine ready for a new request in the cycle after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
    else $error("engine not ready after a write");

endmodule

bind shard_range_lookup_top srl_checker u_srl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
